// ===== src/mlsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_pkg
// Shared codes, widths and reset values for the motion-linked siren controller.
// ----------------------------------------------------------------------------
package mlsc_pkg;

  // Configuration register widths and reset values
  localparam int SIREN_W      = 10;
  localparam int HOLD_W       = 8;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [SIREN_W-1:0] SIREN_RESET = SIREN_W'(10);
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(10);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_AUTO_LINK = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIREN_SEC = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_SEC  = 2'd2;

  // Operation mode
  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_t;

  // Manual command
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Status report to app
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_ON   = 2'd1;
  localparam logic [1:0] REP_OFF  = 2'd2;

  // Audio action
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

endpackage

// ===== src/motion_linked_siren_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_linked_siren_controller_top
// Poll-step siren controller: motion-linked auto mode with hold-off and
// tail countdown, plus manual open/close commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word contents
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready   | one poll step (tick, motion, link, cmd)
//  out_    | out | out_tvalid/tready  | one status word per poll step
//  cfg_    | in  | cfg_we             | register write, index cfg_addr
//
//  One word per clock: each accepted step updates the control state and
//  loads the result register in the same cycle.
//  The result register sets the rate; in_tready drops only while a result
//  is stalled by out_tready. Reset (rst_n low, synchronous) puts the block
//  in auto mode with the siren off and the registers at their defaults.
// ----------------------------------------------------------------------------
module motion_linked_siren_controller_top
  import mlsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // bit0 second_tick, bit1 motion_level, bit2 link_enable, bits4:3 command
  input  logic [7:0]            in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bit0 siren_on, bits2:1 report_event, bits4:3 sound_action, bits6:5 op_mode
  output logic [7:0]            out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic               auto_link_on_r;
  logic [SIREN_W-1:0] siren_seconds_r;
  logic [HOLD_W-1:0]  hold_seconds_r;

  // Control state
  mode_t              mode_r, mode_nxt;
  logic               sounding_r, sounding_nxt;
  logic               detect_active_r, detect_active_nxt;
  logic               detect_reported_r, detect_reported_nxt;
  logic [HOLD_W-1:0]  hold_count_r, hold_count_nxt;
  logic               tail_active_r, tail_active_nxt;
  logic [SIREN_W-1:0] tail_count_r, tail_count_nxt;

  // Result register
  logic [7:0]         out_data_r;
  logic               out_valid_r;
  logic [1:0]         report;
  logic [1:0]         action;

  // Input word fields
  logic               tick;
  logic               motion;
  logic               link_en;
  logic [1:0]         cmd;
  logic               in_fire;

  assign tick    = in_tdata[0];
  assign motion  = in_tdata[1];
  assign link_en = in_tdata[2];
  assign cmd     = in_tdata[4:3];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_link_on_r  <= 1'b0;
      siren_seconds_r <= SIREN_RESET;
      hold_seconds_r  <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AUTO_LINK: auto_link_on_r  <= cfg_wdata[0];
        REG_SIREN_SEC: siren_seconds_r <= cfg_wdata[SIREN_W-1:0];
        REG_HOLD_SEC:  hold_seconds_r  <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Step logic: manual command first, then the mode behavior
  always_comb begin
    mode_nxt            = mode_r;
    sounding_nxt        = sounding_r;
    detect_active_nxt   = detect_active_r;
    detect_reported_nxt = detect_reported_r;
    hold_count_nxt      = hold_count_r;
    tail_active_nxt     = tail_active_r;
    tail_count_nxt      = tail_count_r;
    report              = REP_NONE;
    action              = ACT_NONE;

    // manual command; a repeated open is ignored, code 3 too
    if (cmd == CMD_OPEN && mode_nxt != MODE_OPEN) begin
      mode_nxt            = MODE_OPEN;
      detect_active_nxt   = 1'b0;
      detect_reported_nxt = 1'b0;
      hold_count_nxt      = '0;
      tail_active_nxt     = 1'b0;
      tail_count_nxt      = '0;
    end else if (cmd == CMD_CLOSE) begin
      if (mode_nxt == MODE_OPEN) begin
        // interrupted open: silent stop, back to auto
        if (sounding_nxt) action = ACT_STOP;
        sounding_nxt        = 1'b0;
        mode_nxt            = MODE_AUTO;
        detect_active_nxt   = 1'b0;
        detect_reported_nxt = 1'b0;
        hold_count_nxt      = '0;
        tail_active_nxt     = 1'b0;
        tail_count_nxt      = '0;
      end else begin
        mode_nxt = MODE_CLOSE;
      end
    end

    unique case (mode_nxt)
      MODE_AUTO: begin
        if (auto_link_on_r && link_en) begin
          if (!tail_active_nxt) begin
            // hold-off tracking of motion
            if (motion) begin
              detect_active_nxt = 1'b1;
              hold_count_nxt    = hold_seconds_r;
            end else if (tick && detect_active_nxt) begin
              if (hold_count_nxt != '0) hold_count_nxt = hold_count_nxt - 1'b1;
              else                      detect_active_nxt = 1'b0;
            end
            if (detect_active_nxt != detect_reported_nxt) begin
              detect_reported_nxt = detect_active_nxt;
              if (detect_active_nxt) begin
                sounding_nxt = 1'b1;
                report       = REP_ON;
                action       = ACT_START;
              end else if (sounding_nxt) begin
                tail_active_nxt = 1'b1;
                tail_count_nxt  = siren_seconds_r;
              end
            end
          end else if (tick) begin
            // tail countdown, motion ignored
            if (tail_count_nxt == '0) begin
              sounding_nxt        = 1'b0;
              report              = REP_OFF;
              action              = ACT_STOP;
              detect_active_nxt   = 1'b0;
              detect_reported_nxt = 1'b0;
              hold_count_nxt      = '0;
              tail_active_nxt     = 1'b0;
              tail_count_nxt      = '0;
            end else begin
              tail_count_nxt = tail_count_nxt - 1'b1;
            end
          end
        end else begin
          // linkage lost
          detect_active_nxt   = 1'b0;
          detect_reported_nxt = 1'b0;
          hold_count_nxt      = '0;
          tail_active_nxt     = 1'b0;
          tail_count_nxt      = '0;
          if (sounding_nxt) begin
            sounding_nxt = 1'b0;
            report       = REP_OFF;
            action       = ACT_STOP;
          end
        end
      end
      MODE_OPEN: begin
        if (!tail_active_nxt) begin
          if (!sounding_nxt) begin
            sounding_nxt = 1'b1;
            report       = REP_ON;
            action       = ACT_START;
          end
          tail_active_nxt = 1'b1;
          tail_count_nxt  = siren_seconds_r;
        end else if (tick) begin
          if (tail_count_nxt == '0) begin
            sounding_nxt        = 1'b0;
            report              = REP_OFF;
            action              = ACT_STOP;
            mode_nxt            = MODE_AUTO;
            detect_active_nxt   = 1'b0;
            detect_reported_nxt = 1'b0;
            hold_count_nxt      = '0;
            tail_active_nxt     = 1'b0;
            tail_count_nxt      = '0;
          end else begin
            tail_count_nxt = tail_count_nxt - 1'b1;
          end
        end
      end
      default: begin
        // manual close: silence and return to auto
        detect_active_nxt   = 1'b0;
        detect_reported_nxt = 1'b0;
        hold_count_nxt      = '0;
        tail_active_nxt     = 1'b0;
        tail_count_nxt      = '0;
        if (sounding_nxt) begin
          sounding_nxt = 1'b0;
          report       = REP_OFF;
          action       = ACT_STOP;
        end
        mode_nxt = MODE_AUTO;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_AUTO;
      sounding_r        <= 1'b0;
      detect_active_r   <= 1'b0;
      detect_reported_r <= 1'b0;
      hold_count_r      <= '0;
      tail_active_r     <= 1'b0;
      tail_count_r      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r            <= mode_nxt;
        sounding_r        <= sounding_nxt;
        detect_active_r   <= detect_active_nxt;
        detect_reported_r <= detect_reported_nxt;
        hold_count_r      <= hold_count_nxt;
        tail_active_r     <= tail_active_nxt;
        tail_count_r      <= tail_count_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {1'b0, mode_nxt, action, report, sounding_nxt};
    end
  end

  // Checks
  a_no_close_left: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_CLOSE)
    else $error("manual close mode persisted past a step");

  a_tail_needs_siren: assert property (@(posedge clk) disable iff (!rst_n)
    tail_active_r |-> sounding_r)
    else $error("countdown running with siren off");

  a_report_matches_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2:1] != REP_NONE) |-> out_data_r[4:3] == out_data_r[2:1])
    else $error("report without matching audio action");

  a_report_on_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2:1] == REP_ON) |-> out_data_r[0])
    else $error("on report with siren off");

endmodule

// ===== verif/tb_motion_linked_siren_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_linked_siren_controller_top
// Self-checking bench for the motion-linked siren controller. Poll steps go
// in on the in_ stream and one status word per step comes back on out_.
// A bit-accurate siren state model predicts every status word. Directed
// cases are followed by random motion bursts under several register
// settings and idle/stall mixes, plus a long output stall.
// ----------------------------------------------------------------------------
module tb_motion_linked_siren_controller_top;
  import mlsc_pkg::*;

  // command code the block must ignore
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic       siren;
    logic [1:0] report;
    logic [1:0] action;
    mode_t      mode;
  } status_t;

  logic                  clk;
  logic                  rst_n;
  logic [7:0]            in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  motion_linked_siren_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Model registers
  logic               m_link_cfg;
  logic [SIREN_W-1:0] m_siren_len;
  logic [HOLD_W-1:0]  m_hold_len;

  // Model state
  mode_t              m_mode;
  logic               m_sounding;
  logic               m_detect;
  logic               m_reported;
  logic [7:0]         m_hold_cnt;
  logic               m_tail_on;
  logic [10:0]        m_tail_cnt;

  status_t            pending_status[$];
  int                 mismatches;
  int                 snd_idle_pct;
  int                 rcv_stall_pct;
  int                 hold_req;
  int                 hold_left;
  logic               motion_on;
  int                 burst_left;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Siren state model
  // ---------------------------------------------------------------------------
  function automatic void clear_motion_tracking();
    m_detect   = 1'b0;
    m_reported = 1'b0;
    m_hold_cnt = '0;
    m_tail_on  = 1'b0;
    m_tail_cnt = '0;
  endfunction

  function automatic void silence_if_sounding(ref status_t st);
    if (m_sounding) begin
      m_sounding = 1'b0;
      st.report  = REP_OFF;
      st.action  = ACT_STOP;
    end
  endfunction

  function automatic void predict_poll_step(input logic tick, input logic motion,
                                            input logic link_en, input logic [1:0] cmd);
    status_t st;
    st.report = REP_NONE;
    st.action = ACT_NONE;

    // manual command first
    if (cmd == CMD_OPEN && m_mode != MODE_OPEN) begin
      m_mode = MODE_OPEN;
      clear_motion_tracking();
    end else if (cmd == CMD_CLOSE) begin
      if (m_mode == MODE_OPEN) begin
        // interrupted manual open: stop without report
        if (m_sounding) st.action = ACT_STOP;
        m_sounding = 1'b0;
        m_mode     = MODE_AUTO;
        clear_motion_tracking();
      end else begin
        m_mode = MODE_CLOSE;
      end
    end

    case (m_mode)
      MODE_AUTO: begin
        if (m_link_cfg && link_en) begin
          if (!m_tail_on) begin
            if (motion) begin
              m_detect   = 1'b1;
              m_hold_cnt = m_hold_len;
            end else if (tick && m_detect) begin
              if (m_hold_cnt != 0) m_hold_cnt = m_hold_cnt - 1'b1;
              else m_detect = 1'b0;
            end
            if (m_detect != m_reported) begin
              m_reported = m_detect;
              if (m_detect) begin
                m_sounding = 1'b1;
                st.report  = REP_ON;
                st.action  = ACT_START;
              end else if (m_sounding) begin
                m_tail_on  = 1'b1;
                m_tail_cnt = 11'(m_siren_len);
              end
            end
          end else if (tick) begin
            if (m_tail_cnt == 0) begin
              silence_if_sounding(st);
              clear_motion_tracking();
            end else begin
              m_tail_cnt = m_tail_cnt - 1'b1;
            end
          end
        end else begin
          clear_motion_tracking();
          silence_if_sounding(st);
        end
      end
      MODE_OPEN: begin
        if (!m_tail_on) begin
          if (!m_sounding) begin
            m_sounding = 1'b1;
            st.report  = REP_ON;
            st.action  = ACT_START;
          end
          m_tail_on  = 1'b1;
          m_tail_cnt = 11'(m_siren_len);
        end else if (tick) begin
          if (m_tail_cnt == 0) begin
            silence_if_sounding(st);
            m_mode = MODE_AUTO;
            clear_motion_tracking();
          end else begin
            m_tail_cnt = m_tail_cnt - 1'b1;
          end
        end
      end
      default: begin
        clear_motion_tracking();
        silence_if_sounding(st);
        m_mode = MODE_AUTO;
      end
    endcase

    st.siren = m_sounding;
    st.mode  = m_mode;
    pending_status.push_back(st);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one poll step, with random sender gaps ahead of it
  task automatic send_step(input logic tick, input logic motion,
                           input logic link_en, input logic [1:0] cmd);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {3'b000, cmd, link_en, motion, tick};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_poll_step(tick, motion, link_en, cmd);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_AUTO_LINK: m_link_cfg  = val[0];
      REG_SIREN_SEC: m_siren_len = val[SIREN_W-1:0];
      REG_HOLD_SEC:  m_hold_len  = val[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic link_on, input int siren_s, input int hold_s);
    go_idle();
    wait_drained();
    write_reg(REG_AUTO_LINK, CFG_DATA_W'(link_on));
    write_reg(REG_SIREN_SEC, CFG_DATA_W'(siren_s));
    write_reg(REG_HOLD_SEC, CFG_DATA_W'(hold_s));
  endtask

  // Motion bursts separated by quiet stretches, with some noise
  task automatic send_motion_traffic(input int count);
    int         roll;
    logic       tick;
    logic       motion;
    logic       link_en;
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        motion_on  = !motion_on;
        burst_left = motion_on ? $urandom_range(1, 4) : $urandom_range(1, 30);
      end
      burst_left--;
      tick    = ($urandom_range(0, 99) < 60);
      motion  = motion_on ^ ($urandom_range(0, 99) < 8);
      link_en = ($urandom_range(0, 99) < 94);
      roll    = $urandom_range(0, 99);
      if (roll < 4)       cmd = CMD_OPEN;
      else if (roll < 8)  cmd = CMD_CLOSE;
      else if (roll < 10) cmd = CMD_BAD;
      else                cmd = CMD_NONE;
      send_step(tick, motion, link_en, cmd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    // defaults: linking not permitted, motion does nothing
    send_step(1'b0, 1'b1, 1'b1, CMD_NONE);
    set_registers(1'b1, 1, 0);
    send_step(1'b1, 1'b1, 1'b1, CMD_BAD);    // unknown command, motion on
    send_step(1'b1, 1'b0, 1'b1, CMD_NONE);   // motion clears, countdown loads
    send_step(1'b1, 1'b1, 1'b1, CMD_NONE);   // motion ignored in countdown
    send_step(1'b1, 1'b0, 1'b1, CMD_NONE);   // countdown expiry
    send_step(1'b0, 1'b1, 1'b1, CMD_NONE);
    send_step(1'b0, 1'b1, 1'b0, CMD_NONE);   // linkage lost
    send_step(1'b0, 1'b0, 1'b0, CMD_OPEN);
    send_step(1'b1, 1'b0, 1'b0, CMD_OPEN);   // repeated open
    send_step(1'b0, 1'b0, 1'b0, CMD_CLOSE);  // close during manual open
    send_step(1'b0, 1'b1, 1'b1, CMD_NONE);
    send_step(1'b0, 1'b1, 1'b1, CMD_OPEN);   // open while sounding
    send_step(1'b1, 1'b0, 1'b1, CMD_NONE);
    send_step(1'b1, 1'b0, 1'b1, CMD_NONE);   // manual countdown expiry
    send_step(1'b0, 1'b0, 1'b1, CMD_CLOSE);  // close while silent
    send_step(1'b0, 1'b1, 1'b1, CMD_NONE);
    send_step(1'b1, 1'b1, 1'b1, CMD_CLOSE);  // close in auto while sounding
    send_step(1'b1, 1'b1, 1'b1, CMD_BAD);
    set_registers(1'b0, 1, 0);
    send_step(1'b1, 1'b1, 1'b1, CMD_NONE);   // permission removed while sounding
    send_step(1'b0, 1'b0, 1'b0, CMD_OPEN);
  endtask

  task automatic test_random_phases();
    set_registers(1'b1, 3, 2);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_motion_traffic(140);
    set_registers(1'b1, 0, 0);
    snd_idle_pct  = 77;
    send_motion_traffic(120);
    set_registers(1'b1, 5, 4);
    snd_idle_pct  = 0;
    rcv_stall_pct = 77;
    send_motion_traffic(130);
    set_registers(1'b0, 2, 1);
    snd_idle_pct  = 12;
    rcv_stall_pct = 12;
    send_motion_traffic(50);
  endtask

  task automatic test_extreme_registers();
    set_registers(1'b1, 1023, 255);
    snd_idle_pct  = 12;
    rcv_stall_pct = 12;
    send_motion_traffic(60);
    set_registers(1'b1, 1, 1);
    send_motion_traffic(40);
  endtask

  // Receiver holds off long; the block fills and stalls its input
  task automatic test_backpressure();
    set_registers(1'b1, 2, 1);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 300;
    send_motion_traffic(40);
    go_idle();
    wait_drained();
    send_motion_traffic(30);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Status word checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.siren  = out_tdata[0];
      got.report = out_tdata[2:1];
      got.action = out_tdata[4:3];
      got.mode   = mode_t'(out_tdata[6:5]);
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected status word %h", $realtime, out_tdata);
      end else begin
        want = pending_status.pop_front();
        if (got.siren !== want.siren || got.report !== want.report ||
            got.action !== want.action || got.mode !== want.mode) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: status mismatch: exp siren=%0d rep=%0d act=%0d mode=%0d,",
                      " got siren=%0d rep=%0d act=%0d mode=%0d"},
                     $realtime, want.siren, want.report, want.action, want.mode,
                     got.siren, got.report, got.action, got.mode);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tvalid     = 1'b0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    mismatches    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 0;
    hold_left     = 0;
    motion_on     = 1'b0;
    burst_left    = 0;
    m_link_cfg    = 1'b0;
    m_siren_len   = SIREN_RESET;
    m_hold_len    = HOLD_RESET;
    m_mode        = MODE_AUTO;
    m_sounding    = 1'b0;
    clear_motion_tracking();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_phases();
    test_backpressure();
    test_extreme_registers();

    go_idle();
    wait_drained();
    repeat (5) @(posedge clk);
    if (pending_status.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
